/* hw/rtl/spwm_pkg.sv */
// ----------------------------------------------------------------------------
// spwm_pkg
// Types, codes and constants for the servo PWM timed move controller.
// ----------------------------------------------------------------------------
`default_nettype none

package spwm_pkg;

	localparam logic [7:0]  NEUTRAL_RESET = 8'd15;
	localparam logic [9:0]  PERIOD_RESET  = 10'd200;
	localparam logic [14:0] NUDGE_RESET   = 15'd100;
	localparam logic [2:0]  SPEED_MAX     = 3'd5;

	localparam logic [14:0] GRAB_LEN_1   = 15'd30000;
	localparam logic [14:0] GRAB_LEN_2   = 15'd21000;
	localparam logic [14:0] GRAB_LEN_3   = 15'd15000;
	localparam logic [14:0] GRAB_LEN_4   = 15'd10000;
	localparam logic [14:0] GRAB_LEN_5   = 15'd12000;
	localparam logic [14:0] UNGRAB_LEN_1 = 15'd30000;
	localparam logic [14:0] UNGRAB_LEN_2 = 15'd15000;
	localparam logic [14:0] UNGRAB_LEN_3 = 15'd15000;
	localparam logic [14:0] UNGRAB_LEN_4 = 15'd10000;
	localparam logic [14:0] UNGRAB_LEN_5 = 15'd10000;

	localparam logic [1:0] REG_NEUTRAL_DUTY = 2'd0;
	localparam logic [1:0] REG_PERIOD_TICKS = 2'd1;
	localparam logic [1:0] REG_NUDGE_TICKS  = 2'd2;

	typedef enum logic [3:0] {
		ACT_TICK       = 4'd0,
		ACT_GRAB       = 4'd1,
		ACT_UNGRAB     = 4'd2,
		ACT_NUDGE_FWD  = 4'd3,
		ACT_NUDGE_BACK = 4'd4,
		ACT_SET_SPEED  = 4'd5,
		ACT_INC        = 4'd6,
		ACT_DEC        = 4'd7,
		ACT_FWD        = 4'd8,
		ACT_BACK       = 4'd9,
		ACT_TOGGLE     = 4'd10,
		ACT_STOP       = 4'd11,
		ACT_GO         = 4'd12
	} action_t;

	typedef struct packed {
		logic [7:0]  neutral_duty;
		logic [9:0]  period_ticks;
		logic [14:0] nudge_ticks;
	} cfg_t;

	typedef struct packed {
		logic [9:0]  tick_counter;
		logic [7:0]  duty_value;
		logic [2:0]  speed_setting;
		logic        direction_forward;
		logic        grabbed_flag;
		logic [14:0] move_countdown;
		logic        pulse_level;
	} state_t;

	function automatic logic [14:0] grab_len(input logic [2:0] speed);
		logic [14:0] len;
		case (speed)
			3'd1: len = GRAB_LEN_1;
			3'd2: len = GRAB_LEN_2;
			3'd3: len = GRAB_LEN_3;
			3'd4: len = GRAB_LEN_4;
			3'd5: len = GRAB_LEN_5;
			default: len = '0;
		endcase
		return len;
	endfunction

	function automatic logic [14:0] ungrab_len(input logic [2:0] speed);
		logic [14:0] len;
		case (speed)
			3'd1: len = UNGRAB_LEN_1;
			3'd2: len = UNGRAB_LEN_2;
			3'd3: len = UNGRAB_LEN_3;
			3'd4: len = UNGRAB_LEN_4;
			3'd5: len = UNGRAB_LEN_5;
			default: len = '0;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/spwm_ifs.sv */
// ----------------------------------------------------------------------------
// spwm_ifs
// Valid/ready channels: input item, result word and configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

interface spwm_item_if;
	logic               valid;
	logic               ready;
	logic [3:0]         action;
	logic signed [15:0] speed_value;

	modport source (output valid, output action, output speed_value, input ready);
	modport sink   (input valid, input action, input speed_value, output ready);
endinterface

interface spwm_result_if;
	logic       valid;
	logic       ready;
	logic       pwm_level;
	logic [7:0] duty_now;
	logic [2:0] speed_now;
	logic       moving_forward;
	logic       hand_grabbed;
	logic       move_busy;

	modport source (output valid, output pwm_level, output duty_now, output speed_now,
		output moving_forward, output hand_grabbed, output move_busy, input ready);
	modport sink   (input valid, input pwm_level, input duty_now, input speed_now,
		input moving_forward, input hand_grabbed, input move_busy, output ready);
endinterface

interface spwm_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [14:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/servo_pwm_timed_move_controller.sv */
// ----------------------------------------------------------------------------
// servo_pwm_timed_move_controller
// Servo PWM generator with timed grab, ungrab and nudge moves.
// ----------------------------------------------------------------------------
// The result word is registered: an accepted input word passes through the
// input register, then the state/result registers.
// Throughput: one word per cycle unless the result stalls; the state update
// is one pass of next-state logic between input and state/result registers.
// Reset: arst_n clears both stages and loads state and registers to their
// reset values; no clearing pass.
`default_nettype none

module servo_pwm_timed_move_controller (
	input  wire logic      clk,
	input  wire logic      arst_n,
	spwm_item_if.sink      item,
	spwm_result_if.source  result,
	spwm_cfg_if.sink       cfg
);

	logic               valid_s1;
	logic [3:0]         action_s1;
	logic signed [15:0] speed_value_s1;
	logic               advance;

	spwm_pkg::cfg_t     cfg_regs;
	spwm_pkg::state_t   state_q;
	spwm_pkg::state_t   state_nxt;

	logic               res_valid_q;
	logic               pwm_level_q;
	logic [7:0]         duty_now_q;
	logic [2:0]         speed_now_q;
	logic               moving_forward_q;
	logic               hand_grabbed_q;
	logic               move_busy_q;

	assign advance    = !res_valid_q || result.ready;
	assign item.ready = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	spwm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_regs)
	);

	spwm_step u_step (
		.action      (action_s1),
		.speed_value (speed_value_s1),
		.cfg         (cfg_regs),
		.cur         (state_q),
		.nxt         (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			action_s1      <= item.action;
			speed_value_s1 <= item.speed_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.tick_counter      <= '0;
			state_q.duty_value        <= spwm_pkg::NEUTRAL_RESET;
			state_q.speed_setting     <= '0;
			state_q.direction_forward <= 1'b1;
			state_q.grabbed_flag      <= 1'b0;
			state_q.move_countdown    <= '0;
			state_q.pulse_level       <= 1'b0;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			pwm_level_q      <= state_nxt.pulse_level;
			duty_now_q       <= state_nxt.duty_value;
			speed_now_q      <= state_nxt.speed_setting;
			moving_forward_q <= state_nxt.direction_forward;
			hand_grabbed_q   <= state_nxt.grabbed_flag;
			move_busy_q      <= (state_nxt.move_countdown != '0);
		end
	end

	assign result.valid          = res_valid_q;
	assign result.pwm_level      = pwm_level_q;
	assign result.duty_now       = duty_now_q;
	assign result.speed_now      = speed_now_q;
	assign result.moving_forward = moving_forward_q;
	assign result.hand_grabbed   = hand_grabbed_q;
	assign result.move_busy      = move_busy_q;

endmodule

`default_nettype wire

/* hw/rtl/spwm_cfg.sv */
// ----------------------------------------------------------------------------
// spwm_cfg
// Configuration register file: neutral duty, frame length, nudge length.
// ----------------------------------------------------------------------------
`default_nettype none

module spwm_cfg (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                wr_en,
	input  wire logic [1:0]          wr_index,
	input  wire logic [14:0]         wr_data,
	output spwm_pkg::cfg_t           cfg
);

	spwm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.neutral_duty <= spwm_pkg::NEUTRAL_RESET;
			cfg_q.period_ticks <= spwm_pkg::PERIOD_RESET;
			cfg_q.nudge_ticks  <= spwm_pkg::NUDGE_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				spwm_pkg::REG_NEUTRAL_DUTY: cfg_q.neutral_duty <= wr_data[7:0];
				spwm_pkg::REG_PERIOD_TICKS: cfg_q.period_ticks <= wr_data[9:0];
				spwm_pkg::REG_NUDGE_TICKS:  cfg_q.nudge_ticks  <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* hw/rtl/spwm_step.sv */
// ----------------------------------------------------------------------------
// spwm_step
// Next-state logic for one tick or command.
// ----------------------------------------------------------------------------
`default_nettype none

module spwm_step (
	input  wire logic [3:0]          action,
	input  wire logic signed [15:0]  speed_value,
	input  wire spwm_pkg::cfg_t      cfg,
	input  wire spwm_pkg::state_t    cur,
	output spwm_pkg::state_t         nxt
);

	logic [8:0]  sum_fwd;
	logic [7:0]  duty_fwd;
	logic [7:0]  duty_back;
	logic [7:0]  duty_moving;
	logic [9:0]  cnt_inc;
	logic [15:0] mag;

	always_comb begin
		sum_fwd     = {1'b0, cfg.neutral_duty} + {6'd0, cur.speed_setting};
		duty_fwd    = sum_fwd[8] ? 8'hFF : sum_fwd[7:0];
		duty_back   = (cfg.neutral_duty >= {5'd0, cur.speed_setting}) ?
			cfg.neutral_duty - {5'd0, cur.speed_setting} : 8'd0;
		duty_moving = cur.direction_forward ? duty_fwd : duty_back;
		cnt_inc     = cur.tick_counter + 10'd1;
		mag         = speed_value[15] ? (~speed_value) + 16'd1 : speed_value;
	end

	always_comb begin
		nxt = cur;
		unique case (spwm_pkg::action_t'(action))
			spwm_pkg::ACT_TICK: begin
				if (cnt_inc < {2'd0, cur.duty_value}) begin
					nxt.tick_counter = cnt_inc;
					nxt.pulse_level  = 1'b1;
				end else if (cnt_inc < cfg.period_ticks) begin
					nxt.tick_counter = cnt_inc;
					nxt.pulse_level  = 1'b0;
				end else begin
					nxt.tick_counter = '0;
				end
				if (cur.move_countdown != '0) begin
					nxt.duty_value     = (cur.move_countdown == 15'd1) ?
						cfg.neutral_duty : duty_moving;
					nxt.move_countdown = cur.move_countdown - 15'd1;
				end
			end
			spwm_pkg::ACT_GRAB: begin
				if (cur.move_countdown == '0 && !cur.grabbed_flag) begin
					nxt.grabbed_flag      = 1'b1;
					nxt.direction_forward = 1'b1;
					nxt.move_countdown    = spwm_pkg::grab_len(cur.speed_setting);
				end
			end
			spwm_pkg::ACT_UNGRAB: begin
				if (cur.move_countdown == '0 && cur.grabbed_flag) begin
					nxt.grabbed_flag      = 1'b0;
					nxt.direction_forward = 1'b0;
					nxt.move_countdown    = spwm_pkg::ungrab_len(cur.speed_setting);
				end
			end
			spwm_pkg::ACT_NUDGE_FWD: begin
				nxt.direction_forward = 1'b1;
				nxt.move_countdown    = cfg.nudge_ticks;
			end
			spwm_pkg::ACT_NUDGE_BACK: begin
				nxt.direction_forward = 1'b0;
				nxt.move_countdown    = cfg.nudge_ticks;
			end
			spwm_pkg::ACT_SET_SPEED: begin
				nxt.speed_setting = (mag > {13'd0, spwm_pkg::SPEED_MAX}) ?
					spwm_pkg::SPEED_MAX : mag[2:0];
			end
			spwm_pkg::ACT_INC: begin
				if (cur.speed_setting < spwm_pkg::SPEED_MAX)
					nxt.speed_setting = cur.speed_setting + 3'd1;
			end
			spwm_pkg::ACT_DEC: begin
				if (cur.speed_setting != '0)
					nxt.speed_setting = cur.speed_setting - 3'd1;
			end
			spwm_pkg::ACT_FWD:    nxt.direction_forward = 1'b1;
			spwm_pkg::ACT_BACK:   nxt.direction_forward = 1'b0;
			spwm_pkg::ACT_TOGGLE: nxt.direction_forward = !cur.direction_forward;
			spwm_pkg::ACT_STOP:   nxt.duty_value = cfg.neutral_duty;
			spwm_pkg::ACT_GO:     nxt.duty_value = duty_moving;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

/* hw/rtl/spwm_chk.sv */
// ----------------------------------------------------------------------------
// spwm_chk
// Port-level checks for the servo PWM timed move controller.
// ----------------------------------------------------------------------------
`default_nettype none

module spwm_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       item_valid,
	input wire logic       item_ready,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic [7:0] res_duty,
	input wire logic [2:0] res_speed,
	input wire logic       res_grabbed
);

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !res_valid)
		else $error("result valid during reset");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_duty) && $stable(res_grabbed))
		else $error("stalled result word changed");

	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_speed <= 3'd5)
		else $error("speed out of range");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> ##1 res_valid)
		else $error("accepted word produced no result");

endmodule

bind servo_pwm_timed_move_controller spwm_chk u_spwm_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item.valid),
	.item_ready  (item.ready),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_duty    (result.duty_now),
	.res_speed   (result.speed_now),
	.res_grabbed (result.hand_grabbed)
);

`default_nettype wire

/* sim/tb_servo_pwm_timed_move_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_servo_pwm_timed_move_controller
// Sends ticks and commands to the servo PWM controller and checks every result
// word against an in-bench model of the controller or a directed row's status.
// A short directed table comes first, then random words over several register
// settings, with idle cycles and stalls on both channels.
// ----------------------------------------------------------------------------

module tb_servo_pwm_timed_move_controller;

	localparam int CLK_PERIOD      = 20;
	localparam int STALL_LIMIT     = 5000;
	localparam int WORDS_PER_PHASE = 90;
	localparam int NUM_PHASES      = 6;
	localparam int HOLD_OFF_AT     = 150;
	localparam int HOLD_OFF_CYCLES = 64;
	localparam int NUM_DIRECTED    = 26;

	localparam logic [3:0] ACT_RESERVED_LO  = 4'd13;
	localparam logic [3:0] ACT_RESERVED_MID = 4'd14;
	localparam logic [3:0] ACT_RESERVED_HI  = 4'd15;

	typedef struct packed {
		logic       pwm;
		logic [7:0] duty;
		logic [2:0] speed;
		logic       fwd;
		logic       grabbed;
		logic       busy;
	} servo_status_t;

	typedef struct packed {
		logic [3:0]    action;
		logic [15:0]   speed_value;
		logic          typed;
		servo_status_t want;
	} stim_row_t;

	localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
		'{spwm_pkg::ACT_TICK, 16'h0000, 1'b1, '{1'b1, 8'd15, 3'd0, 1'b1, 1'b0, 1'b0}},
		'{ACT_RESERVED_LO, 16'h0000, 1'b1, '{1'b1, 8'd15, 3'd0, 1'b1, 1'b0, 1'b0}},
		'{ACT_RESERVED_HI, 16'h7FFF, 1'b1, '{1'b1, 8'd15, 3'd0, 1'b1, 1'b0, 1'b0}},
		'{spwm_pkg::ACT_SET_SPEED, 16'h8000, 1'b1, '{1'b1, 8'd15, 3'd5, 1'b1, 1'b0, 1'b0}},
		'{spwm_pkg::ACT_SET_SPEED, 16'h7FFF, 1'b1, '{1'b1, 8'd15, 3'd5, 1'b1, 1'b0, 1'b0}},
		'{spwm_pkg::ACT_SET_SPEED, 16'hFFFD, 1'b1, '{1'b1, 8'd15, 3'd3, 1'b1, 1'b0, 1'b0}},
		'{spwm_pkg::ACT_SET_SPEED, 16'h0000, 1'b1, '{1'b1, 8'd15, 3'd0, 1'b1, 1'b0, 1'b0}},
		'{spwm_pkg::ACT_DEC, 16'hFFFF, 1'b1, '{1'b1, 8'd15, 3'd0, 1'b1, 1'b0, 1'b0}},
		'{spwm_pkg::ACT_GRAB, 16'h0000, 1'b1, '{1'b1, 8'd15, 3'd0, 1'b1, 1'b1, 1'b0}},
		'{spwm_pkg::ACT_GRAB, 16'h0000, 1'b1, '{1'b1, 8'd15, 3'd0, 1'b1, 1'b1, 1'b0}},
		'{spwm_pkg::ACT_UNGRAB, 16'h0000, 1'b1, '{1'b1, 8'd15, 3'd0, 1'b0, 1'b0, 1'b0}},
		'{spwm_pkg::ACT_SET_SPEED, 16'h0004, 1'b0, '0},
		'{spwm_pkg::ACT_INC, 16'h0000, 1'b0, '0},
		'{spwm_pkg::ACT_INC, 16'h0000, 1'b1, '{1'b1, 8'd15, 3'd5, 1'b0, 1'b0, 1'b0}},
		'{spwm_pkg::ACT_GO, 16'h0000, 1'b1, '{1'b1, 8'd10, 3'd5, 1'b0, 1'b0, 1'b0}},
		'{spwm_pkg::ACT_FWD, 16'h0000, 1'b1, '{1'b1, 8'd10, 3'd5, 1'b1, 1'b0, 1'b0}},
		'{spwm_pkg::ACT_GO, 16'h0000, 1'b1, '{1'b1, 8'd20, 3'd5, 1'b1, 1'b0, 1'b0}},
		'{spwm_pkg::ACT_BACK, 16'h0000, 1'b0, '0},
		'{spwm_pkg::ACT_TOGGLE, 16'h0000, 1'b0, '0},
		'{spwm_pkg::ACT_STOP, 16'h0000, 1'b0, '0},
		'{spwm_pkg::ACT_GRAB, 16'h0000, 1'b0, '0},
		'{spwm_pkg::ACT_GRAB, 16'h0000, 1'b0, '0},
		'{spwm_pkg::ACT_UNGRAB, 16'h0000, 1'b0, '0},
		'{spwm_pkg::ACT_TICK, 16'h0000, 1'b0, '0},
		'{spwm_pkg::ACT_NUDGE_BACK, 16'h0000, 1'b0, '0},
		'{ACT_RESERVED_MID, 16'hFFFF, 1'b0, '0}
	};

	localparam spwm_pkg::cfg_t PHASE_CFG [NUM_PHASES] = '{
		'{8'd5,   10'd2,    15'd1},
		'{8'd250, 10'd1023, 15'd30000},
		'{8'd253, 10'd40,   15'd7},
		'{8'd2,   10'd60,   15'd0},
		'{8'd100, 10'd50,   15'd12},
		'{8'd15,  10'd200,  15'd5}
	};

	logic clk;
	logic arst_n;

	spwm_item_if   item_if();
	spwm_result_if res_if();
	spwm_cfg_if    cfg_if();

	servo_pwm_timed_move_controller uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if),
		.result (res_if),
		.cfg    (cfg_if)
	);

	logic [7:0]  neutral;
	logic [9:0]  period;
	logic [14:0] nudge;
	logic [9:0]  count;
	logic [7:0]  duty;
	logic [2:0]  speed;
	logic        fwd;
	logic        grabbed;
	logic [14:0] countdown;
	logic        level;

	servo_status_t pending_status[$];
	int words_in;
	int words_out;
	int fail_count;
	int quiet;

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic logic [7:0] running_duty();
		logic [8:0] sum;
		if (fwd) begin
			sum = {1'b0, neutral} + 9'(speed);
			return (sum > 9'd255) ? 8'd255 : sum[7:0];
		end
		return (neutral >= 8'(speed)) ? neutral - 8'(speed) : 8'd0;
	endfunction

	function automatic servo_status_t advance_servo(input logic [3:0] act,
		input logic [15:0] sv);
		logic [16:0] mag;
		mag = sv[15] ? (17'h10000 - {1'b0, sv}) : {1'b0, sv};
		case (act)
			spwm_pkg::ACT_TICK: begin
				count = count + 10'd1;
				if (count < {2'b00, duty})
					level = 1'b1;
				else if (count < period)
					level = 1'b0;
				else
					count = '0;
				if (countdown != '0) begin
					duty = (countdown == 15'd1) ? neutral : running_duty();
					countdown = countdown - 15'd1;
				end
			end
			spwm_pkg::ACT_GRAB: begin
				if (countdown == '0 && !grabbed) begin
					grabbed = 1'b1;
					fwd = 1'b1;
					case (speed)
						3'd1: countdown = spwm_pkg::GRAB_LEN_1;
						3'd2: countdown = spwm_pkg::GRAB_LEN_2;
						3'd3: countdown = spwm_pkg::GRAB_LEN_3;
						3'd4: countdown = spwm_pkg::GRAB_LEN_4;
						3'd5: countdown = spwm_pkg::GRAB_LEN_5;
						default: countdown = '0;
					endcase
				end
			end
			spwm_pkg::ACT_UNGRAB: begin
				if (countdown == '0 && grabbed) begin
					grabbed = 1'b0;
					fwd = 1'b0;
					case (speed)
						3'd1: countdown = spwm_pkg::UNGRAB_LEN_1;
						3'd2: countdown = spwm_pkg::UNGRAB_LEN_2;
						3'd3: countdown = spwm_pkg::UNGRAB_LEN_3;
						3'd4: countdown = spwm_pkg::UNGRAB_LEN_4;
						3'd5: countdown = spwm_pkg::UNGRAB_LEN_5;
						default: countdown = '0;
					endcase
				end
			end
			spwm_pkg::ACT_NUDGE_FWD: begin
				fwd = 1'b1;
				countdown = nudge;
			end
			spwm_pkg::ACT_NUDGE_BACK: begin
				fwd = 1'b0;
				countdown = nudge;
			end
			spwm_pkg::ACT_SET_SPEED:
				speed = (mag > 17'(spwm_pkg::SPEED_MAX)) ? spwm_pkg::SPEED_MAX : mag[2:0];
			spwm_pkg::ACT_INC: if (speed < spwm_pkg::SPEED_MAX) speed = speed + 3'd1;
			spwm_pkg::ACT_DEC: if (speed != 3'd0) speed = speed - 3'd1;
			spwm_pkg::ACT_FWD: fwd = 1'b1;
			spwm_pkg::ACT_BACK: fwd = 1'b0;
			spwm_pkg::ACT_TOGGLE: fwd = ~fwd;
			spwm_pkg::ACT_STOP: duty = neutral;
			spwm_pkg::ACT_GO: duty = running_duty();
			default: ;
		endcase
		return '{level, duty, speed, fwd, grabbed, (countdown != '0)};
	endfunction

	task automatic push_word(input logic [3:0] act, input logic [15:0] sv,
		input logic typed, input servo_status_t want);
		servo_status_t predicted;
		int gap;
		gap = (words_in < 220) ? 21 : (words_in < 440) ? 50 : 0;
		while ($urandom_range(0, 99) < gap) begin
			item_if.valid <= 1'b0;
			@(posedge clk);
		end
		item_if.valid       <= 1'b1;
		item_if.action      <= act;
		item_if.speed_value <= sv;
		do @(posedge clk); while (!item_if.ready);
		predicted = advance_servo(act, sv);
		pending_status.push_back(typed ? want : predicted);
		words_in++;
	endtask

	task automatic drain();
		item_if.valid <= 1'b0;
		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			spwm_pkg::REG_NEUTRAL_DUTY: neutral = val[7:0];
			spwm_pkg::REG_PERIOD_TICKS: period = val[9:0];
			spwm_pkg::REG_NUDGE_TICKS: nudge = val;
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	initial begin : stimulus
		logic [3:0]  act;
		logic [15:0] sv;
		int          r;
		neutral    = spwm_pkg::NEUTRAL_RESET;
		period     = spwm_pkg::PERIOD_RESET;
		nudge      = spwm_pkg::NUDGE_RESET;
		count      = '0;
		duty       = spwm_pkg::NEUTRAL_RESET;
		speed      = '0;
		fwd        = 1'b1;
		grabbed    = 1'b0;
		countdown  = '0;
		level      = 1'b0;
		words_in   = 0;
		fail_count = 0;

		arst_n              <= 1'b0;
		item_if.valid       <= 1'b0;
		item_if.action      <= spwm_pkg::ACT_TICK;
		item_if.speed_value <= '0;
		cfg_if.valid        <= 1'b0;
		cfg_if.index        <= spwm_pkg::REG_NEUTRAL_DUTY;
		cfg_if.data         <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p <= NUM_PHASES; p++) begin
			if (p == 0) begin
				for (int i = 0; i < NUM_DIRECTED; i++)
					push_word(DIRECTED[i].action, DIRECTED[i].speed_value,
						DIRECTED[i].typed, DIRECTED[i].want);
			end else begin
				drain();
				write_reg(spwm_pkg::REG_NEUTRAL_DUTY,
					15'(PHASE_CFG[p - 1].neutral_duty));
				write_reg(spwm_pkg::REG_PERIOD_TICKS,
					15'(PHASE_CFG[p - 1].period_ticks));
				write_reg(spwm_pkg::REG_NUDGE_TICKS, PHASE_CFG[p - 1].nudge_ticks);
				cfg_if.valid <= 1'b0;
			end
			for (int i = 0; i < WORDS_PER_PHASE; i++) begin
				r  = $urandom_range(0, 99);
				sv = 16'($urandom);
				if (r < 8)
					act = 4'($urandom_range(0, 15));
				else if (countdown > 15'd40 && r < 30)
					act = r[0] ? spwm_pkg::ACT_NUDGE_FWD : spwm_pkg::ACT_NUDGE_BACK;
				else if (countdown == '0 && r < 20)
					act = grabbed ? spwm_pkg::ACT_UNGRAB : spwm_pkg::ACT_GRAB;
				else if (r < 28) begin
					act = spwm_pkg::ACT_SET_SPEED;
					if (r[0])
						sv = 16'($urandom_range(0, 14)) - 16'd7;
				end else if (r < 34)
					act = r[0] ? spwm_pkg::ACT_INC : spwm_pkg::ACT_DEC;
				else if (r < 40) begin
					case ($urandom_range(0, 2))
						0: act = spwm_pkg::ACT_FWD;
						1: act = spwm_pkg::ACT_BACK;
						default: act = spwm_pkg::ACT_TOGGLE;
					endcase
				end else if (r < 46)
					act = r[0] ? spwm_pkg::ACT_STOP : spwm_pkg::ACT_GO;
				else
					act = spwm_pkg::ACT_TICK;
				push_word(act, sv, 1'b0, '0);
			end
		end

		drain();
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin : result_sink
		servo_status_t want;
		int            stall;
		bit            held;
		words_out = 0;
		held      = 1'b0;
		res_if.ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = (words_in < 220) ? 50 : (words_in < 440) ? 21 : 0;
			if (words_out == HOLD_OFF_AT && !held) begin
				held = 1'b1;
				res_if.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			res_if.ready <= ($urandom_range(0, 99) >= stall);
			@(posedge clk);
			if (res_if.valid && res_if.ready) begin
				words_out++;
				if (pending_status.size() == 0) begin
					$error("result word with no prediction waiting");
					fail_count++;
				end else begin
					want = pending_status.pop_front();
					check_field("pwm_level", want.pwm, res_if.pwm_level);
					check_field("duty_now", want.duty, res_if.duty_now);
					check_field("speed_now", want.speed, res_if.speed_now);
					check_field("moving_forward", want.fwd, res_if.moving_forward);
					check_field("hand_grabbed", want.grabbed, res_if.hand_grabbed);
					check_field("move_busy", want.busy, res_if.move_busy);
				end
			end
		end
	end

	initial quiet = 0;

	always @(posedge clk) begin
		if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
			(cfg_if.valid && cfg_if.ready)) begin
			quiet <= 0;
		end else if (quiet >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

endmodule
